// ===== sv/key_value_table_assert.svh =====
// ----------------------------------------------------------------------------
// key_value_table_assert
// assertion macros used by the key/value table controller
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_ASSERT_SVH
`define KEY_VALUE_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define KVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define KVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg
// types and constants of the key/value table
// ----------------------------------------------------------------------------
package kvt_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W         = 8;
  localparam int VAL_W         = 8;
  localparam int RAM_W         = KEY_W + VAL_W;

  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

  // command codes
  localparam logic [1:0] CMD_PUT = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXISTS    = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
  } res_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [RAM_W-1:0] wr_data;
  } ram_req_t;

endpackage

// ===== sv/kvt_ram.sv =====
// ----------------------------------------------------------------------------
// kvt_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module kvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/kvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvt_ctrl
// command sequencer: scans the entry ram, then commits put or delete
// ----------------------------------------------------------------------------
`include "key_value_table_assert.svh"

module kvt_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  kvt_pkg::cmd_t                       cmd,
  output logic                                res_valid,
  input  logic                                res_ready,
  output kvt_pkg::res_t                       res,
  output kvt_pkg::ram_req_t                   ram_req,
  input  logic [kvt_pkg::RAM_W-1:0]           ram_rd_data
);

  kvt_pkg::state_t                      state;
  kvt_pkg::state_t                      state_next;
  kvt_pkg::cmd_t                        cmd_q;
  logic [kvt_pkg::CNT_W-1:0]            cnt;
  logic                                 rd_pend;
  logic [kvt_pkg::IDX_W-1:0]            cmp_idx;
  logic [kvt_pkg::TABLE_ENTRIES-1:0]    valid;
  logic                                 hit;
  logic [kvt_pkg::IDX_W-1:0]            hit_idx;
  logic [kvt_pkg::VAL_W-1:0]            hit_val;
  logic                                 free_found;
  logic [kvt_pkg::IDX_W-1:0]            free_idx;
  logic                                 commit;
  logic                                 put_ok;
  logic                                 del_commit;
  logic                                 key_match;
  logic                                 slot_free;
  kvt_pkg::res_t                        result;

  // compare of the word just read against the command key
  assign key_match = rd_pend && valid[cmp_idx]
                     && (ram_rd_data[kvt_pkg::KEY_W-1:0] == cmd_q.key);
  assign slot_free = rd_pend && !valid[cmp_idx];

  assign put_ok     = (cmd_q.command == kvt_pkg::CMD_PUT) && !hit && free_found;
  assign del_commit = commit && (cmd_q.command == kvt_pkg::CMD_DEL) && hit;

  // result of the finished scan
  always_comb begin
    result = '0;
    case (cmd_q.command)
      kvt_pkg::CMD_PUT: begin
        if (hit) begin
          result.status = kvt_pkg::ST_EXISTS;
        end else if (!free_found) begin
          result.status = kvt_pkg::ST_FULL;
        end
      end
      kvt_pkg::CMD_GET: begin
        if (hit) begin
          result.read_value = hit_val;
        end else begin
          result.status = kvt_pkg::ST_NOT_FOUND;
        end
      end
      kvt_pkg::CMD_DEL: begin
        if (!hit) begin
          result.status = kvt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kvt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, handshakes and ram requests
  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    res_valid  = 1'b0;
    res        = result;
    ram_req    = '0;
    commit     = 1'b0;
    unique case (state)
      kvt_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          state_next = kvt_pkg::S_SCAN;
        end
      end
      kvt_pkg::S_SCAN: begin
        if (cnt != kvt_pkg::SCAN_END) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = cnt[kvt_pkg::IDX_W-1:0];
        end else begin
          state_next = kvt_pkg::S_DONE;
        end
      end
      kvt_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          commit     = 1'b1;
          state_next = kvt_pkg::S_IDLE;
        end
        ram_req.wr_en   = commit && put_ok;
        ram_req.wr_addr = free_idx;
        ram_req.wr_data = {cmd_q.value, cmd_q.key};
      end
      default: begin
        state_next = kvt_pkg::S_IDLE;
      end
    endcase
  end

  // scan control, hit flags and valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rd_pend    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      valid      <= '0;
    end else begin
      if (state == kvt_pkg::S_IDLE && cmd_valid) begin
        cnt        <= '0;
        rd_pend    <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end
      if (state == kvt_pkg::S_SCAN) begin
        rd_pend <= ram_req.rd_en;
        if (cnt != kvt_pkg::SCAN_END) begin
          cnt <= cnt + 1'b1;
        end
        if (key_match && !hit) begin
          hit <= 1'b1;
        end
        if (slot_free && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (commit && put_ok) begin
        valid[free_idx] <= 1'b1;
      end
      if (del_commit) begin
        valid[hit_idx] <= 1'b0;
      end
    end
  end

  // command word and scan payload
  always_ff @(posedge clk) begin
    if (state == kvt_pkg::S_IDLE && cmd_valid) begin
      cmd_q <= cmd;
    end
    if (state == kvt_pkg::S_SCAN) begin
      cmp_idx <= cnt[kvt_pkg::IDX_W-1:0];
      if (key_match && !hit) begin
        hit_idx <= cmp_idx;
        hit_val <= ram_rd_data[kvt_pkg::RAM_W-1:kvt_pkg::KEY_W];
      end
      if (slot_free && !free_found) begin
        free_idx <= cmp_idx;
      end
    end
  end

  // checks
  `KVT_ASSERT_NOW(a_wr_only_done, ram_req.wr_en, state == kvt_pkg::S_DONE, "ram write outside done")
  `KVT_ASSERT_NOW(a_put_free_slot, ram_req.wr_en, !valid[ram_req.wr_addr], "put into a valid slot")
  `KVT_ASSERT_NOW(a_rd_in_range, ram_req.rd_en, cnt < kvt_pkg::SCAN_END, "read past table end")
  `KVT_ASSERT_NEXT(a_del_clears, del_commit, !valid[$past(hit_idx)], "delete left slot valid")
  `KVT_ASSERT_NOW(a_ready_no_res, cmd_ready, !res_valid, "command taken with result pending")

endmodule

// ===== sv/key_value_table.sv =====
// ----------------------------------------------------------------------------
// key_value_table
// key/value store with put, get and delete over a scanned entry ram
//
// channel   dir  tdata                      tuser
// s_axis    in   key[7:0], value[15:8]      command[1:0]
// m_axis    out  read_value[7:0]            status[1:0]
//
// one command at a time; the next command is accepted only after the scan of
// the entry ram through its single read port, one entry per cycle, and the
// commit of the current command.
// reset clears the valid marks at once, no clearing pass is needed.
// a stalled result sits in the output register; a finished command waits
// for that register to free before it commits.
// ----------------------------------------------------------------------------
module key_value_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // key[7:0], value[15:8]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // read_value[7:0]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  kvt_pkg::cmd_t                   cmd_in;
  kvt_pkg::res_t                   res;
  kvt_pkg::ram_req_t               ram_req;
  logic [kvt_pkg::RAM_W-1:0]       ram_rd_data;
  logic                            res_valid;
  logic                            res_ready;

  // unpack the input word
  assign cmd_in.command = s_axis_tuser;
  assign cmd_in.key     = s_axis_tdata[7:0];
  assign cmd_in.value   = s_axis_tdata[15:8];

  kvt_ram #(
    .WIDTH (kvt_pkg::RAM_W),
    .DEPTH (kvt_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_rd_data)
  );

  kvt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (s_axis_tvalid),
    .cmd_ready   (s_axis_tready),
    .cmd         (cmd_in),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= res.read_value;
      m_axis_tuser <= res.status;
    end
  end

endmodule

// ===== dv/tb_key_value_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_value_table
// self-checking bench for the key/value table: put, get and delete words go
// in over the slave stream, every command is mirrored by a table model in the
// bench, and each result word on the master stream is checked against the
// oldest predicted result, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_key_value_table;

  // command code that the block ignores
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 1950;
  localparam int MAX_REPORTS  = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'h0000;  // key[7:0], value[15:8]
  logic [1:0]  s_axis_tuser = 2'b00;     // command[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;             // read_value[7:0]
  logic [1:0]  m_axis_tuser;             // status[1:0]

  key_value_table uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // words waiting to be sent, results waiting to arrive
  kvt_pkg::cmd_t pending_cmds[$];
  kvt_pkg::res_t expected_results[$];
  kvt_pkg::cmd_t drive_cmd;
  int   items_total    = 0;
  int   items_accepted = 0;
  int   error_count    = 0;
  int   send_idle_pct;
  int   recv_idle_pct;

  // table model used for prediction
  logic       tbl_valid [kvt_pkg::TABLE_ENTRIES];
  logic [7:0] tbl_key   [kvt_pkg::TABLE_ENTRIES];
  logic [7:0] tbl_value [kvt_pkg::TABLE_ENTRIES];
  int         tbl_count;

  // keys the stimulus generator believes are stored
  logic [7:0] gen_keys[$];

  initial begin
    for (int i = 0; i < kvt_pkg::TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = 8'h00;
      tbl_value[i] = 8'h00;
    end
    tbl_count = 0;
  end

  // apply one command to the table model and return its result
  function automatic kvt_pkg::res_t predict_result(input logic [1:0] cmd,
                                                   input logic [7:0] k,
                                                   input logic [7:0] v);
    kvt_pkg::res_t r;
    int   hit;
    int   slot;
    r.status     = kvt_pkg::ST_OK;
    r.read_value = '0;
    hit  = kvt_pkg::TABLE_ENTRIES;
    slot = kvt_pkg::TABLE_ENTRIES;
    for (int i = kvt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_key[i] == k) hit = i;
      if (!tbl_valid[i]) slot = i;
    end
    case (cmd)
      kvt_pkg::CMD_PUT: begin
        if (hit < kvt_pkg::TABLE_ENTRIES) begin
          r.status = kvt_pkg::ST_EXISTS;
        end else if (slot >= kvt_pkg::TABLE_ENTRIES) begin
          r.status = kvt_pkg::ST_FULL;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_key[slot]   = k;
          tbl_value[slot] = v;
          tbl_count++;
        end
      end
      kvt_pkg::CMD_GET: begin
        if (hit < kvt_pkg::TABLE_ENTRIES) r.read_value = tbl_value[hit];
        else r.status = kvt_pkg::ST_NOT_FOUND;
      end
      kvt_pkg::CMD_DEL: begin
        if (hit < kvt_pkg::TABLE_ENTRIES) begin
          tbl_valid[hit] = 1'b0;
          if (tbl_count > 0) tbl_count--;
        end else begin
          r.status = kvt_pkg::ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int gen_find(input logic [7:0] k);
    for (int i = 0; i < gen_keys.size(); i++) begin
      if (gen_keys[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(255));
  endfunction

  // a stored key if there is one, else any key
  function automatic logic [7:0] present_key();
    if (gen_keys.size() == 0) return random_byte();
    return gen_keys[$urandom_range(gen_keys.size() - 1)];
  endfunction

  // queue one word and track which keys it leaves stored
  task automatic add_item(input logic [1:0] cmd, input logic [7:0] k, input logic [7:0] v);
    kvt_pkg::cmd_t c;
    int   idx;
    c.command = cmd;
    c.key     = k;
    c.value   = v;
    pending_cmds.push_back(c);
    idx = gen_find(k);
    if (cmd == kvt_pkg::CMD_PUT && idx < 0 && gen_keys.size() < kvt_pkg::TABLE_ENTRIES)
      gen_keys.push_back(k);
    if (cmd == kvt_pkg::CMD_DEL && idx >= 0) gen_keys.delete(idx);
  endtask

  // fill, look up, then delete everything so the table empties again
  task automatic clean_session();
    int n_put;
    int n_look;
    int idx;
    logic [7:0] k;
    n_put  = ($urandom_range(7) == 0) ? kvt_pkg::TABLE_ENTRIES + $urandom_range(3)
                                      : $urandom_range(1, 8);
    n_look = $urandom_range(1, 8);
    repeat (n_put) begin
      k = ($urandom_range(4) == 0) ? present_key() : random_byte();
      add_item(kvt_pkg::CMD_PUT, k, random_byte());
    end
    repeat (n_look) begin
      case ($urandom_range(5))
        0: add_item(kvt_pkg::CMD_GET, random_byte(), random_byte());
        1: begin
          k = present_key();
          add_item(kvt_pkg::CMD_DEL, k, random_byte());
          add_item(kvt_pkg::CMD_PUT, k, random_byte());
        end
        default: add_item(kvt_pkg::CMD_GET, present_key(), random_byte());
      endcase
    end
    while (gen_keys.size() != 0) begin
      idx = $urandom_range(gen_keys.size() - 1);
      k   = gen_keys[idx];
      add_item(kvt_pkg::CMD_DEL, k, random_byte());
      // stale lookups after removal
      if ($urandom_range(7) == 0) add_item(kvt_pkg::CMD_GET, k, random_byte());
      if ($urandom_range(9) == 0) add_item(kvt_pkg::CMD_DEL, k, random_byte());
    end
  endtask

  // any command, any key, including the unused code
  task automatic noise_burst();
    repeat ($urandom_range(3, 12)) begin
      add_item(2'($urandom_range(3)), random_byte(), random_byte());
    end
  endtask

  // idle rates by phase of the run
  always_comb begin
    if (items_accepted < items_total / 3) begin
      send_idle_pct = 30;
      recv_idle_pct = 58;
    end else if (items_accepted < (2 * items_total) / 3) begin
      send_idle_pct = 58;
      recv_idle_pct = 30;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // driver: present the next pending word once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_cmd = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drive_cmd.value, drive_cmd.key};
        s_axis_tuser  <= drive_cmd.command;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    if (error_count < MAX_REPORTS)
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    error_count++;
  endtask

  // monitor: predict on every accepted command, check every accepted result
  always @(posedge clk) begin
    kvt_pkg::res_t exp_r;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_result(s_axis_tuser, s_axis_tdata[7:0],
                                                  s_axis_tdata[15:8]));
        items_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word, status", -1, m_axis_tuser);
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tuser !== exp_r.status)
            report_mismatch("status", exp_r.status, m_axis_tuser);
          if (m_axis_tdata !== exp_r.read_value)
            report_mismatch("read_value", exp_r.read_value, $signed(m_axis_tdata));
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    // empty table lookups and the ignored code
    add_item(kvt_pkg::CMD_GET, 8'h80, 8'h00);
    add_item(kvt_pkg::CMD_DEL, 8'h7F, 8'h00);
    add_item(CMD_NONE, 8'hFF, 8'hFF);
    // fill every slot, extreme keys and values first
    add_item(kvt_pkg::CMD_PUT, 8'h80, 8'h7F);
    add_item(kvt_pkg::CMD_PUT, 8'h7F, 8'h80);
    add_item(kvt_pkg::CMD_PUT, 8'h00, 8'h00);
    add_item(kvt_pkg::CMD_PUT, 8'hFF, 8'hFF);
    for (int i = 1; i <= kvt_pkg::TABLE_ENTRIES - 4; i++)
      add_item(kvt_pkg::CMD_PUT, 8'(i), random_byte());
    // full table, present key wins over full
    add_item(kvt_pkg::CMD_PUT, 8'h37, 8'h11);
    add_item(kvt_pkg::CMD_PUT, 8'h7F, 8'h22);
    add_item(kvt_pkg::CMD_GET, 8'h80, 8'h00);
    add_item(kvt_pkg::CMD_GET, 8'hFF, 8'h00);
    // freed slot is reused
    add_item(kvt_pkg::CMD_DEL, 8'h00, 8'h00);
    add_item(kvt_pkg::CMD_PUT, 8'h63, 8'h5A);

    while (pending_cmds.size() < 25 + RANDOM_ITEMS) begin
      if ($urandom_range(4) == 0) noise_burst();
      else clean_session();
    end
    items_total = pending_cmds.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted < items_total || expected_results.size() != 0) @(posedge clk);
    repeat (4 * kvt_pkg::TABLE_ENTRIES) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/kvt_pkg.sv
sv/kvt_ram.sv
sv/kvt_ctrl.sv
sv/key_value_table.sv
dv/tb_key_value_table.sv
